// ===== rtl/core/phes_pkg.sv =====
package phes_pkg;

  // One byte of the capture file as it enters the block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  // One converted byte as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_FILE_HDR,
    PH_REC_HDR,
    PH_PAYLOAD,
    PH_PASS
  } phase_e;

  // Status codes on the output.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_PASS        = 2'd3;

  localparam logic [31:0] CAPTURE_MAGIC = 32'hA1B2C3D4;
  localparam logic [15:0] VER_MAJOR     = 16'd2;
  localparam logic [15:0] VER_MINOR     = 16'd4;

  // Byte offsets inside the file header and the record header.
  localparam logic [4:0] FILE_ID_END   = 5'd8;
  localparam logic [4:0] FILE_HDR_END  = 5'd24;
  localparam logic [4:0] CAPLEN_END    = 5'd12;
  localparam logic [4:0] REC_HDR_END   = 5'd16;

  // Index of the final byte in a queue entry.
  localparam logic [2:0] LAST_ONE  = 3'd0;
  localparam logic [2:0] LAST_WORD = 3'd3;
  localparam logic [2:0] LAST_ID   = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 2;

  // A run of one to eight output bytes caused by one input byte.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [2:0]      last_idx;
    logic [1:0]      status;
  } entry_t;

endpackage

// ===== rtl/core/phes_front.sv =====
module phes_front #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  phes_pkg::in_item_t in_data_i,
  output logic               in_stall_o,
  input  logic               full_i,
  output logic               push_o,
  output phes_pkg::entry_t   entry_o
);
  import phes_pkg::*;

  phase_e                 phase_q, phase_d, phase_eff;
  logic [4:0]             off_q, off_d, off_eff, off_inc;
  logic [LENGTH_BITS-1:0] rem_q, rem_d, rem_eff, rem_next, cap_sat;
  logic [7:0][7:0]        grp_q, grp_d, grp_new;
  logic [2:0]             pos;
  logic                   xfer, word_done, hi, magic_bad, ver_bad, push_raw;
  logic [31:0]            cap;
  logic [1:0]             err;
  entry_t                 word_ent;

  assign in_stall_o = full_i;
  assign xfer       = in_valid_i && !full_i;

  // A start of file restarts parsing with this byte.
  assign phase_eff = in_data_i.start_of_file ? PH_FILE_HDR : phase_q;
  assign off_eff   = in_data_i.start_of_file ? 5'd0 : off_q;
  assign rem_eff   = in_data_i.start_of_file ? '0 : rem_q;
  assign off_inc   = off_eff + 5'd1;
  assign pos       = off_eff[2:0];
  assign word_done = (off_inc[1:0] == 2'd0);
  assign hi        = off_eff[2];

  always_comb begin
    grp_new      = grp_q;
    grp_new[pos] = in_data_i.data_byte;
  end

  assign magic_bad = ({grp_new[3], grp_new[2], grp_new[1], grp_new[0]} != CAPTURE_MAGIC);
  assign ver_bad   = ({grp_new[5], grp_new[4]} != VER_MAJOR) ||
                     ({grp_new[7], grp_new[6]} != VER_MINOR);
  assign err       = magic_bad ? ST_BAD_MAGIC : ST_BAD_VERSION;

  // Captured length is the third record word, held in the low half of the group.
  assign cap = {grp_new[3], grp_new[2], grp_new[1], grp_new[0]};
  always_comb begin
    if ((cap >> LENGTH_BITS) != 32'd0) begin
      cap_sat = '1;
    end else begin
      cap_sat = cap[LENGTH_BITS-1:0];
    end
  end

  assign rem_next = rem_eff - LENGTH_BITS'(rem_eff != '0);

  always_comb begin
    word_ent          = '0;
    word_ent.bytes[0] = grp_new[{hi, 2'd3}];
    word_ent.bytes[1] = grp_new[{hi, 2'd2}];
    word_ent.bytes[2] = grp_new[{hi, 2'd1}];
    word_ent.bytes[3] = grp_new[{hi, 2'd0}];
    word_ent.last_idx = LAST_WORD;
    word_ent.status   = ST_OK;
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    rem_d   = rem_q;
    grp_d   = grp_q;
    if (xfer) begin
      phase_d = phase_eff;
      off_d   = off_eff;
      rem_d   = rem_eff;
      unique case (phase_eff)
        PH_FILE_HDR: begin
          grp_d = grp_new;
          off_d = off_inc;
          if (off_inc == FILE_ID_END) begin
            if (magic_bad || ver_bad) begin
              phase_d = PH_PASS;
              off_d   = 5'd0;
            end
          end else if (off_inc >= FILE_HDR_END && word_done) begin
            phase_d = PH_REC_HDR;
            off_d   = 5'd0;
          end
        end
        PH_REC_HDR: begin
          grp_d = grp_new;
          off_d = off_inc;
          if (word_done) begin
            if (off_inc == CAPLEN_END) begin
              rem_d = cap_sat;
            end else if (off_inc >= REC_HDR_END) begin
              off_d = 5'd0;
              if (rem_eff != '0) begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          rem_d = rem_next;
          if (rem_next == '0) begin
            phase_d = PH_REC_HDR;
            off_d   = 5'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    push_raw = 1'b0;
    entry_o  = word_ent;
    unique case (phase_eff)
      PH_FILE_HDR: begin
        if (off_inc == FILE_ID_END) begin
          push_raw         = 1'b1;
          entry_o.last_idx = LAST_ID;
          if (magic_bad || ver_bad) begin
            entry_o.bytes  = grp_new;
            entry_o.status = err;
          end else begin
            entry_o.bytes  = {grp_new[6], grp_new[7], grp_new[4], grp_new[5],
                              grp_new[0], grp_new[1], grp_new[2], grp_new[3]};
            entry_o.status = ST_OK;
          end
        end else if (off_inc > FILE_ID_END && word_done) begin
          push_raw = 1'b1;
        end
      end
      PH_REC_HDR: begin
        push_raw = word_done;
      end
      PH_PAYLOAD: begin
        push_raw         = 1'b1;
        entry_o.bytes    = '0;
        entry_o.bytes[0] = in_data_i.data_byte;
        entry_o.last_idx = LAST_ONE;
        entry_o.status   = ST_OK;
      end
      default: begin
        push_raw         = 1'b1;
        entry_o.bytes    = '0;
        entry_o.bytes[0] = in_data_i.data_byte;
        entry_o.last_idx = LAST_ONE;
        entry_o.status   = ST_PASS;
      end
    endcase
  end

  assign push_o = xfer && push_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FILE_HDR;
      off_q   <= 5'd0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

endmodule

// ===== rtl/core/phes_queue.sv =====
module phes_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  phes_pkg::entry_t entry_i,
  input  logic             pop_i,
  output phes_pkg::entry_t entry_o,
  output logic             valid_o,
  output logic             full_o
);
  import phes_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/phes_back.sv =====
module phes_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phes_pkg::entry_t    entry_i,
  input  logic                valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output phes_pkg::out_item_t out_data_o
);
  import phes_pkg::*;

  entry_t     cur_q, cur_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       xfer, at_last;

  assign out_valid_o = busy_q;
  assign xfer        = busy_q && !out_stall_i;
  assign at_last     = (idx_q == cur_q.last_idx);

  assign out_data_o.out_byte    = cur_q.bytes[idx_q];
  assign out_data_o.status      = cur_q.status;
  assign out_data_o.last_of_run = at_last;

  // The next run is loaded in the same cycle that the last byte of the current one leaves.
  assign pop_o = valid_i && (!busy_q || (xfer && at_last));

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (pop_o) begin
      cur_d  = entry_i;
      idx_d  = 3'd0;
      busy_d = 1'b1;
    end else if (xfer) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ===== rtl/core/pcap_header_endian_swapper.sv =====
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_stall_o | in_data_i  (data_byte, start_of_file)
// output  | out       | out_valid_o / out_stall_i | out_data_o (out_byte, status, last_of_run)
//
// Unless stalled, one byte is taken per cycle and one byte is delivered per cycle.
// A completed file identification yields eight bytes and a completed header word four,
// so the output port sets the rate; a two-entry run queue plus the output run
// register absorb the bursts, and the input stalls only while that queue is full.
// Reset clears the parser and the queue at once; there is no clearing pass.
module pcap_header_endian_swapper #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  phes_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output phes_pkg::out_item_t out_data_o
);
  import phes_pkg::*;

  entry_t push_ent, head_ent;
  logic   push, pop, q_valid, q_full;

  phes_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (push_ent)
  );

  phes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_ent),
    .pop_i   (pop),
    .entry_o (head_ent),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  phes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_ent),
    .valid_i     (q_valid),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/phes_checker.sv =====
module phes_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input phes_pkg::out_item_t out_data_o
);
  import phes_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Inside a run the next byte follows without a gap.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("run interrupted before its last byte");

  // The queue only drains when a run finishes on the output.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !(out_valid_o && !out_stall_i) |=> in_stall_o)
    else $error("input stall released without an output transfer");

endmodule

bind pcap_header_endian_swapper phes_checker u_phes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
